// ----- rtl/core/gsc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsc_pkg
// shared types and constants of the gesture swipe and circle classifier
// ----------------------------------------------------------------------------
package gsc_pkg;

  localparam int unsigned THR_BITS          = 16;
  localparam logic [THR_BITS-1:0] THR_RESET = 16'd100;
  localparam int unsigned CIRCLE_MIN_POINTS = 10;
  localparam int unsigned OUT_BITS          = 8;
  localparam logic [1:0] K_LAST_AXIS        = 2'd2;
  localparam logic [1:0] K_THR              = 2'd3;
  localparam int unsigned MUL_K25           = 25;
  localparam int unsigned MUL_K26           = 26;

  typedef enum logic [1:0] {
    FN_START = 2'd0,
    FN_ADD   = 2'd1,
    FN_END   = 2'd2,
    FN_NONE  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    G_NONE   = 3'd0,
    G_RIGHT  = 3'd1,
    G_LEFT   = 3'd2,
    G_UP     = 3'd3,
    G_DOWN   = 3'd4,
    G_CIRCLE = 3'd5
  } gesture_t;

  typedef enum logic [2:0] {
    MS_SQ, MS_NP, MS_D2, MS_F2, MS_LHS, MS_BB, MS_RHS
  } mul_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SW_MUL, ST_SW_CHK, ST_SUM, ST_SUM_END, ST_RD, ST_NP, ST_D2,
    ST_SQRT, ST_F2, ST_LHS, ST_BB, ST_RHS, ST_DONE
  } state_t;

  typedef struct packed {
    logic     sw_chk;
    logic     sum_rd;
    logic     p2_rd;
    logic     clr_i;
    logic     inc_i;
    logic     mul_start;
    mul_sel_t mul_sel;
    logic [1:0] k;
    logic     sq_start;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic cls_go;
    logic n_ge_min;
    logic is_swipe;
    logic i_last;
    logic mul_done;
    logic sq_done;
  } dp_status_t;

endpackage

// ----- rtl/core/gsc_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsc_mul
// shift-add multiplier, one multiplier bit per cycle, early finish
// ----------------------------------------------------------------------------
module gsc_mul #(
  parameter int unsigned W = 81
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic         busy,
  output logic         done,
  output logic [W-1:0] prod
);

  logic [W-1:0] mc;
  logic [W-1:0] mp;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (mp == '0)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod <= '0;
      mc   <= a;
      mp   <= b;
    end else if (busy && (mp != '0)) begin
      if (mp[0]) begin
        prod <= prod + mc;
      end
      mc <= mc << 1;
      mp <= mp >> 1;
    end
  end

endmodule

// ----- rtl/core/gsc_sqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsc_sqrt
// floor square root, one result bit per cycle
// ----------------------------------------------------------------------------
module gsc_sqrt #(
  parameter int unsigned QW = 54
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [QW-1:0]   v,
  output logic            busy,
  output logic            done,
  output logic [QW/2-1:0] root
);

  logic [QW-1:0] x;
  logic [QW-1:0] r;
  logic [QW-1:0] bm;
  logic [QW:0]   trial;
  logic          ge;

  assign trial = {1'b0, r} + {1'b0, bm};
  assign ge    = ({1'b0, x} >= trial);
  assign root  = r[QW/2-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (bm == '0)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x  <= v;
      r  <= '0;
      bm <= QW'(1) << (QW - 2);
    end else if (busy && (bm != '0)) begin
      if (ge) begin
        x <= x - trial[QW-1:0];
        r <= (r >> 1) + bm;
      end else begin
        r <= r >> 1;
      end
      bm <= bm >> 2;
    end
  end

endmodule

// ----- rtl/core/gsc_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsc_dp
// point store, stroke bookkeeping and the swipe and circle arithmetic
// ----------------------------------------------------------------------------
module gsc_dp #(
  parameter int unsigned MAX_POINTS = 256,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [gsc_pkg::THR_BITS-1:0]       cfg_data,
  input  logic                               in_acc,
  input  gsc_pkg::func_t                     in_func,
  input  logic [3*COORD_BITS-1:0]            in_pt,
  input  gsc_pkg::dp_cmd_t                   cmd,
  output gsc_pkg::dp_status_t                status,
  output logic [gsc_pkg::OUT_BITS-1:0]       out_data
);
  import gsc_pkg::*;

  localparam int unsigned CB  = COORD_BITS;
  localparam int unsigned PW  = 3 * CB;
  localparam int unsigned AB  = $clog2(MAX_POINTS);
  localparam int unsigned NB  = $clog2(MAX_POINTS + 1);
  localparam int unsigned SW  = CB + NB;
  localparam int unsigned DW  = CB + NB + 1;
  localparam int unsigned QW  = 2 * DW + 2;
  localparam int unsigned FW  = DW + 1;
  localparam int unsigned AW  = 2 * FW + NB;
  localparam int unsigned BW  = FW + NB;
  localparam int unsigned LW  = 2 * FW + 2 * NB + 5;
  localparam int unsigned MW  = (CB + 1 > THR_BITS) ? CB + 1 : THR_BITS;
  localparam int unsigned SQW = 2 * MW;

  logic [PW-1:0]  mem [MAX_POINTS];
  logic [PW-1:0]  rdata;
  logic [PW-1:0]  first_pt;
  logic [PW-1:0]  last_pt;
  logic [NB-1:0]  count;
  logic           armed;
  logic           ovf;
  logic           sum_v;
  logic [THR_BITS-1:0] thr;
  logic [NB-1:0]  i;
  logic signed [SW-1:0] s_acc [3];
  logic [SQW-1:0] d2;
  logic [SQW-1:0] t2;
  logic [DW-1:0]  dval;
  logic [QW-1:0]  q2;
  logic [FW-1:0]  froot;
  logic [AW-1:0]  acc_a;
  logic [BW-1:0]  acc_b;
  logic [LW-1:0]  lhs;
  logic [LW-1:0]  tmp;
  gesture_t       gest;

  logic           is_start, is_add, is_end, full, we;
  logic [AB-1:0]  waddr;
  logic signed [CB:0] dxa [3];
  logic [CB:0]    mag [3];
  logic [MW-1:0]  sq_src;
  logic signed [CB-1:0] psel;
  logic signed [SW-1:0] ssel;
  logic [CB-1:0]  pmag;
  logic [NB+4:0]  n25;
  logic [LW-1:0]  mul_a, mul_b, prod;
  logic           mul_busy, mul_done, sq_busy, sq_done;
  logic [QW/2-1:0] root;
  logic signed [DW:0] npos, nval, diff;
  gesture_t       swcode;
  logic           dom_x, dom_y;

  assign is_start = in_acc && (in_func == FN_START);
  assign is_add   = in_acc && (in_func == FN_ADD) && armed;
  assign is_end   = in_acc && (in_func == FN_END) && armed;
  assign full     = (count == NB'(MAX_POINTS));
  assign we       = is_start || (is_add && !full) || is_end;

  always_comb begin
    if (is_start) begin
      waddr = '0;
    end else if (full) begin
      waddr = AB'(MAX_POINTS - 1);
    end else begin
      waddr = count[AB-1:0];
    end
  end

  // point store
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= in_pt;
    end
    if (cmd.sum_rd || cmd.p2_rd) begin
      rdata <= mem[i[AB-1:0]];
    end
  end

  // stroke control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      armed <= 1'b0;
      ovf   <= 1'b0;
      sum_v <= 1'b0;
      thr   <= THR_RESET;
    end else begin
      sum_v <= cmd.sum_rd;
      if (cfg_we) begin
        thr <= cfg_data;
      end
      if (is_start) begin
        count <= NB'(1);
        armed <= 1'b1;
        ovf   <= 1'b0;
      end else if (is_add || is_end) begin
        if (full) begin
          ovf <= 1'b1;
        end else begin
          count <= count + NB'(1);
        end
        if (is_end) begin
          armed <= 1'b0;
        end
      end
    end
  end

  // swipe terms
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dxa[k] = $signed({last_pt[k*CB+CB-1], last_pt[k*CB +: CB]})
             - $signed({first_pt[k*CB+CB-1], first_pt[k*CB +: CB]});
      mag[k] = dxa[k][CB] ? (CB+1)'(-dxa[k]) : (CB+1)'(dxa[k]);
    end
  end

  assign dom_x = (mag[0] > mag[1]) && (mag[0] > mag[2]);
  assign dom_y = (mag[1] > mag[0]) && (mag[1] > mag[2]);

  always_comb begin
    priority if (dom_x) begin
      swcode = dxa[0][CB] ? G_LEFT : G_RIGHT;
    end else if (dom_y) begin
      swcode = dxa[1][CB] ? G_DOWN : G_UP;
    end else begin
      swcode = G_NONE;
    end
  end

  always_comb begin
    unique case (cmd.k)
      2'd0:    sq_src = MW'(mag[0]);
      2'd1:    sq_src = MW'(mag[1]);
      2'd2:    sq_src = MW'(mag[2]);
      default: sq_src = MW'(thr);
    endcase
    unique case (cmd.k)
      2'd0:    begin psel = rdata[0 +: CB];    ssel = s_acc[0]; end
      2'd1:    begin psel = rdata[CB +: CB];   ssel = s_acc[1]; end
      default: begin psel = rdata[2*CB +: CB]; ssel = s_acc[2]; end
    endcase
  end

  assign pmag = psel[CB-1] ? CB'(-psel) : CB'(psel);
  assign n25  = (NB+5)'(count) * (NB+5)'(MUL_K25);

  always_comb begin
    unique case (cmd.mul_sel)
      MS_SQ: begin
        mul_a = LW'(sq_src);
        mul_b = LW'(sq_src);
      end
      MS_NP: begin
        mul_a = LW'(count);
        mul_b = LW'(pmag);
      end
      MS_D2: begin
        mul_a = LW'(dval);
        mul_b = LW'(dval);
      end
      MS_F2: begin
        mul_a = LW'(froot);
        mul_b = LW'(froot);
      end
      MS_LHS: begin
        mul_a = LW'(acc_a);
        mul_b = LW'(n25);
      end
      MS_BB: begin
        mul_a = LW'(acc_b);
        mul_b = LW'(acc_b);
      end
      MS_RHS: begin
        mul_a = tmp;
        mul_b = LW'(MUL_K26);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  gsc_mul #(.W(LW)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .done  (mul_done),
    .prod  (prod)
  );

  gsc_sqrt #(.QW(QW)) u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.sq_start),
    .v     (q2),
    .busy  (sq_busy),
    .done  (sq_done),
    .root  (root)
  );

  assign npos = $signed({1'b0, prod[DW-1:0]});
  assign nval = psel[CB-1] ? -npos : npos;
  assign diff = nval - (DW+1)'(ssel);

  // accumulators and result
  always_ff @(posedge clk) begin
    if (is_start) begin
      first_pt <= in_pt;
    end
    if (is_end) begin
      last_pt <= in_pt;
      d2      <= '0;
      acc_a   <= '0;
      acc_b   <= '0;
      for (int k = 0; k < 3; k++) begin
        s_acc[k] <= '0;
      end
    end
    if (sum_v) begin
      for (int k = 0; k < 3; k++) begin
        s_acc[k] <= s_acc[k] + SW'($signed(rdata[k*CB +: CB]));
      end
    end
    if (cmd.clr_i) begin
      i <= '0;
    end else if (cmd.inc_i) begin
      i <= i + NB'(1);
    end
    if (cmd.p2_rd) begin
      q2 <= '0;
    end
    if (sq_done) begin
      froot <= root[FW-1:0];
    end
    if (cmd.sw_chk) begin
      gest <= (d2 > t2) ? swcode : G_NONE;
    end
    if (mul_done) begin
      unique case (cmd.mul_sel)
        MS_SQ: begin
          if (cmd.k == K_THR) begin
            t2 <= prod[SQW-1:0];
          end else begin
            d2 <= d2 + prod[SQW-1:0];
          end
        end
        MS_NP:  dval <= diff[DW] ? DW'(-diff) : DW'(diff);
        MS_D2:  q2 <= q2 + prod[QW-1:0];
        MS_F2: begin
          acc_a <= acc_a + prod[AW-1:0];
          acc_b <= acc_b + BW'(froot);
        end
        MS_LHS: lhs <= prod;
        MS_BB:  tmp <= prod;
        MS_RHS: gest <= ((acc_b != '0) && (lhs < prod)) ? G_CIRCLE : G_NONE;
        default: ;
      endcase
    end
    if (cmd.out_load) begin
      out_data <= OUT_BITS'({ovf, gest});
    end
  end

  assign status.cls_go   = is_end;
  assign status.n_ge_min = (count >= NB'(CIRCLE_MIN_POINTS));
  assign status.is_swipe = (d2 > t2) && (dom_x || dom_y);
  assign status.i_last   = (i == count - NB'(1));
  assign status.mul_done = mul_done;
  assign status.sq_done  = sq_done;

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= NB'(MAX_POINTS))
    else $error("point count past capacity");

  a_mul_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_start |-> !mul_busy && !sq_busy)
    else $error("multiplier started while an operation runs");

  a_sq_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.sq_start |-> !sq_busy && !mul_busy)
    else $error("square root started while an operation runs");

endmodule

// ----- rtl/core/gsc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsc_ctrl
// sequencer for item intake, swipe test, circle passes and result output
// ----------------------------------------------------------------------------
module gsc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  gsc_pkg::dp_status_t status,
  output gsc_pkg::dp_cmd_t    cmd,
  output logic                s_tready,
  output logic                m_tvalid,
  input  logic                m_tready
);
  import gsc_pkg::*;

  state_t     st, st_next;
  logic [1:0] k, k_next;
  logic       op_run;
  logic       done;

  assign done = status.mul_done || status.sq_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= ST_IDLE;
      k        <= '0;
      op_run   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      st <= st_next;
      k  <= k_next;
      if (cmd.mul_start || cmd.sq_start) begin
        op_run <= 1'b1;
      end else if (done) begin
        op_run <= 1'b0;
      end
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // next state
  always_comb begin
    st_next = st;
    k_next  = k;
    unique case (st)
      ST_IDLE: begin
        k_next = '0;
        if (status.cls_go) begin
          st_next = ST_SW_MUL;
        end
      end
      ST_SW_MUL: begin
        if (done) begin
          k_next = k + 2'd1;
          if (k == K_THR) begin
            st_next = ST_SW_CHK;
          end
        end
      end
      ST_SW_CHK: begin
        if (status.is_swipe || !status.n_ge_min) begin
          st_next = ST_DONE;
        end else begin
          st_next = ST_SUM;
        end
      end
      ST_SUM: begin
        if (status.i_last) begin
          st_next = ST_SUM_END;
        end
      end
      ST_SUM_END: st_next = ST_RD;
      ST_RD: begin
        k_next  = '0;
        st_next = ST_NP;
      end
      ST_NP: begin
        if (done) begin
          st_next = ST_D2;
        end
      end
      ST_D2: begin
        if (done) begin
          k_next = k + 2'd1;
          st_next = (k == K_LAST_AXIS) ? ST_SQRT : ST_NP;
        end
      end
      ST_SQRT: begin
        if (done) begin
          st_next = ST_F2;
        end
      end
      ST_F2: begin
        if (done) begin
          st_next = status.i_last ? ST_LHS : ST_RD;
        end
      end
      ST_LHS: begin
        if (done) begin
          st_next = ST_BB;
        end
      end
      ST_BB: begin
        if (done) begin
          st_next = ST_RHS;
        end
      end
      ST_RHS: begin
        if (done) begin
          st_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          st_next = ST_IDLE;
        end
      end
      default: st_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd         = '0;
    cmd.k       = k;
    cmd.mul_sel = MS_SQ;
    s_tready    = 1'b0;
    unique case (st)
      ST_IDLE:    s_tready = 1'b1;
      ST_SW_MUL: begin
        cmd.mul_sel   = MS_SQ;
        cmd.mul_start = !op_run;
      end
      ST_SW_CHK: begin
        cmd.sw_chk = 1'b1;
        cmd.clr_i  = 1'b1;
      end
      ST_SUM: begin
        cmd.sum_rd = 1'b1;
        cmd.inc_i  = 1'b1;
      end
      ST_SUM_END: cmd.clr_i = 1'b1;
      ST_RD:      cmd.p2_rd = 1'b1;
      ST_NP: begin
        cmd.mul_sel   = MS_NP;
        cmd.mul_start = !op_run;
      end
      ST_D2: begin
        cmd.mul_sel   = MS_D2;
        cmd.mul_start = !op_run;
      end
      ST_SQRT:    cmd.sq_start = !op_run;
      ST_F2: begin
        cmd.mul_sel   = MS_F2;
        cmd.mul_start = !op_run;
        cmd.inc_i     = done && !status.i_last;
      end
      ST_LHS: begin
        cmd.mul_sel   = MS_LHS;
        cmd.mul_start = !op_run;
      end
      ST_BB: begin
        cmd.mul_sel   = MS_BB;
        cmd.mul_start = !op_run;
      end
      ST_RHS: begin
        cmd.mul_sel   = MS_RHS;
        cmd.mul_start = !op_run;
      end
      ST_DONE:    cmd.out_load = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  a_idle_no_op: assert property (@(posedge clk) disable iff (rst)
    (st == ST_IDLE) |-> !op_run)
    else $error("operation still running in idle");

  a_rise_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(st == ST_DONE))
    else $error("result shown outside the output step");

endmodule

// ----- rtl/core/gesture_swipe_circle_classifier_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gesture_swipe_circle_classifier_top
// 3-d gesture stroke collector with swipe and circle classification
// ----------------------------------------------------------------------------
// Start, add and end items are taken one per cycle while the block is idle and
// write their point straight into the on-chip store. An end item then blocks
// input while the stroke is classified: four serial squarings for the swipe
// test, and for strokes of ten or more points without a swipe one sweep of
// the store for the centroid plus, per point, seven shift-add
// multiplications and a bit-serial square root, followed by three wide
// multiplications. The serial multiplier (one multiplier bit per cycle) and
// the square root unit (one root bit per cycle) set the classification
// time. The result waits in an output register.
module gesture_swipe_circle_classifier_top #(
  parameter int unsigned MAX_POINTS = 256,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [gsc_pkg::THR_BITS-1:0]           cfg_data,   // swipe_distance_threshold
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [((3*COORD_BITS+7)/8)*8-1:0]      s_tdata,    // point_x, point_y, point_z
  input  logic [1:0]                             s_tuser,    // func
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [gsc_pkg::OUT_BITS-1:0]           m_tdata     // gesture, points_dropped
);
  import gsc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_acc;

  assign cfg_ready = 1'b1;
  assign in_acc    = s_tvalid && s_tready;

  gsc_dp #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_valid),
    .cfg_data (cfg_data),
    .in_acc   (in_acc),
    .in_func  (func_t'(s_tuser)),
    .in_pt    (s_tdata[3*COORD_BITS-1:0]),
    .cmd      (cmd),
    .status   (status),
    .out_data (m_tdata)
  );

  gsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .status   (status),
    .cmd      (cmd),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
  );

endmodule

// ----- sim/tb_gesture_swipe_circle_classifier_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gesture_swipe_circle_classifier_top
// This testbench drives gesture strokes into the classifier and checks every
// result against its own model of the block. The stimulus covers the
// extremes, each swipe direction, axis ties, circles, store overflow, ignored
// items and several threshold settings. Both stream sides pause at random,
// and once the output side holds off long enough to stall the input.
// ----------------------------------------------------------------------------
import gsc_pkg::*;

class gesture_scoreboard;
  localparam int MAXP = 256;
  int sx[MAXP];
  int sy[MAXP];
  int sz[MAXP];
  int count;
  bit armed;
  bit dropped;
  longint unsigned thr;
  logic [3:0] pending[$];
  int mismatches;
  int results;

  function new();
    count = 0;
    armed = 0;
    dropped = 0;
    thr = THR_RESET;
    mismatches = 0;
    results = 0;
  endfunction

  function void put_point(int idx, int x, int y, int z);
    sx[idx] = x;
    sy[idx] = y;
    sz[idx] = z;
  endfunction

  function bit circle_fit(int n);
    longint s0, s1, s2, d;
    longint unsigned q2, f, r, t, asum, bsum;
    logic [127:0] lhs, rhs;
    if (n < CIRCLE_MIN_POINTS) return 0;
    s0 = 0; s1 = 0; s2 = 0;
    for (int i = 0; i < n; i++) begin
      s0 += sx[i]; s1 += sy[i]; s2 += sz[i];
    end
    asum = 0; bsum = 0;
    for (int i = 0; i < n; i++) begin
      q2 = 0;
      d = n * longint'(sx[i]) - s0; if (d < 0) d = -d; q2 += d * d;
      d = n * longint'(sy[i]) - s1; if (d < 0) d = -d; q2 += d * d;
      d = n * longint'(sz[i]) - s2; if (d < 0) d = -d; q2 += d * d;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
        t = r | (64'd1 << b);
        if (t * t <= q2) r = t;
      end
      f = r;
      bsum += f;
      asum += f * f;
    end
    if (bsum == 0) return 0;
    lhs = 128'(asum) * 128'(25 * n);
    rhs = 128'(bsum) * 128'(bsum) * 128'd26;
    return lhs < rhs;
  endfunction

  function gesture_t classify(int n);
    longint dx, dy, dz;
    longint unsigned ax, ay, az;
    if (n < 2) return G_NONE;
    dx = sx[n-1] - sx[0]; dy = sy[n-1] - sy[0]; dz = sz[n-1] - sz[0];
    ax = dx < 0 ? -dx : dx; ay = dy < 0 ? -dy : dy; az = dz < 0 ? -dz : dz;
    if (ax * ax + ay * ay + az * az > thr * thr) begin
      if (ax > ay && ax > az) return dx > 0 ? G_RIGHT : G_LEFT;
      if (ay > ax && ay > az) return dy > 0 ? G_UP : G_DOWN;
    end
    return circle_fit(n) ? G_CIRCLE : G_NONE;
  endfunction

  function void note_input(func_t fn, int x, int y, int z);
    gesture_t g;
    if (fn == FN_START) begin
      put_point(0, x, y, z);
      count = 1;
      armed = 1;
      dropped = 0;
      return;
    end
    if (fn == FN_NONE || !armed) return;
    if (fn == FN_ADD) begin
      if (count < MAXP) begin
        put_point(count, x, y, z);
        count++;
      end else dropped = 1;
      return;
    end
    if (count < MAXP) begin
      put_point(count, x, y, z);
      count++;
    end else begin
      put_point(MAXP - 1, x, y, z);
      dropped = 1;
    end
    armed = 0;
    g = classify(count);
    pending.push_back({dropped, g});
  endfunction

  function void check_result(logic [7:0] data);
    logic [3:0] want;
    results++;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", data);
      return;
    end
    want = pending.pop_front();
    if (data[2:0] !== want[2:0] || data[3] !== want[3]) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d: gesture exp %0d got %0d, dropped exp %0d got %0d",
                 results, want[2:0], data[2:0], want[3], data[3]);
    end
  endfunction
endclass

module tb_gesture_swipe_circle_classifier_top;
  localparam int MAXP = 256;

  logic clk = 0;
  logic rst = 1;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [THR_BITS-1:0] cfg_data = '0;
  logic s_tvalid = 0;
  logic s_tready;
  logic [47:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [OUT_BITS-1:0] m_tdata;

  gesture_scoreboard sb = new();
  int sent = 0;
  bit no_gaps = 0;
  bit stim_done = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  gesture_swipe_circle_classifier_top DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // called at a falling edge, returns at a falling edge
  task automatic send_point(func_t fn, int x, int y, int z);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      s_tvalid = 0;
      repeat (gap) @(negedge clk);
    end
    s_tdata = {z[15:0], y[15:0], x[15:0]};
    s_tuser = fn;
    s_tvalid = 1;
    do @(posedge clk); while (!s_tready);
    sb.note_input(fn, $signed(x[15:0]), $signed(y[15:0]), $signed(z[15:0]));
    sent++;
    @(negedge clk);
  endtask

  task automatic write_threshold(logic [15:0] val);
    s_tvalid = 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    cfg_data = val;
    cfg_valid = 1;
    do @(posedge clk); while (!cfg_ready);
    sb.thr = val;
    @(negedge clk);
    cfg_valid = 0;
  endtask

  function automatic int rnd_coord();
    return $signed(16'($urandom()));
  endfunction

  function automatic int clip(int v);
    return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
  endfunction

  task automatic line_stroke(int npts);
    int x0, y0, z0, dx, dy, dz;
    x0 = $urandom_range(0, 20000) - 10000;
    y0 = $urandom_range(0, 20000) - 10000;
    z0 = $urandom_range(0, 20000) - 10000;
    dx = $urandom_range(0, 1200) - 600;
    dy = $urandom_range(0, 1200) - 600;
    dz = $urandom_range(0, 400) - 200;
    send_point(FN_START, x0, y0, z0);
    for (int i = 1; i < npts - 1; i++)
      send_point(FN_ADD, clip(x0 + i * dx), clip(y0 + i * dy), clip(z0 + i * dz));
    send_point(FN_END, clip(x0 + (npts - 1) * dx), clip(y0 + (npts - 1) * dy),
               clip(z0 + (npts - 1) * dz));
  endtask

  task automatic circle_stroke(int npts, int jitter);
    int cx, cy, cz, r, x, y;
    real ang;
    cx = $urandom_range(0, 20000) - 10000;
    cy = $urandom_range(0, 20000) - 10000;
    cz = $urandom_range(0, 2000) - 1000;
    r = $urandom_range(20, 12000);
    for (int i = 0; i < npts; i++) begin
      ang = 6.2831853 * i / (npts - 1);
      x = clip(cx + $rtoi(r * $cos(ang)) + int'($urandom_range(0, 2 * jitter)) - jitter);
      y = clip(cy + $rtoi(r * $sin(ang)) + int'($urandom_range(0, 2 * jitter)) - jitter);
      send_point(i == 0 ? FN_START : (i == npts - 1 ? FN_END : FN_ADD), x, y, cz);
    end
  endtask

  task automatic noise_stroke(int npts);
    send_point(FN_START, rnd_coord(), rnd_coord(), rnd_coord());
    for (int i = 1; i < npts - 1; i++) begin
      if ($urandom_range(0, 9) == 0)
        send_point(func_t'($urandom_range(0, 3) == 0 ? FN_NONE : FN_ADD),
                   rnd_coord(), rnd_coord(), rnd_coord());
      else
        send_point(FN_ADD, rnd_coord(), rnd_coord(), rnd_coord());
    end
    send_point(FN_END, rnd_coord(), rnd_coord(), rnd_coord());
  endtask

  task automatic full_stroke(bit end_early);
    int n;
    n = end_early ? MAXP - 1 : MAXP + $urandom_range(1, 4);
    send_point(FN_START, 0, 0, 0);
    for (int i = 1; i < n; i++)
      send_point(FN_ADD, rnd_coord() >>> 4, rnd_coord() >>> 4, rnd_coord() >>> 4);
    send_point(FN_END, rnd_coord(), rnd_coord(), rnd_coord());
  endtask

  // output side
  initial begin
    int gap;
    bit held;
    held = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = no_gaps ? 0 : $urandom_range(0, 18);
      if (!held && sb.results == 30) begin
        gap = 3000;
        held = 1;
      end
      if (gap > 0) begin
        m_tready = 0;
        repeat (gap) @(negedge clk);
      end
      m_tready = 1;
      do @(posedge clk); while (!m_tvalid);
      sb.check_result(m_tdata);
      @(negedge clk);
    end
  end

  initial begin
    int kind;
    int strokes;
    logic [15:0] thr_set[5];
    thr_set = '{16'd0, 16'hFFFF, 16'd1000, 16'd100, 16'd7};
    repeat (11) @(negedge clk);
    rst = 0;
    @(negedge clk);

    // directed
    send_point(FN_ADD, 5, 5, 5);
    send_point(FN_END, 5, 5, 5);
    send_point(FN_NONE, -1, -1, -1);
    send_point(FN_START, -32768, -32768, -32768);
    send_point(FN_END, 32767, 0, 0);
    send_point(FN_START, 32767, 0, 0);
    send_point(FN_END, -32768, 0, 0);
    send_point(FN_START, 0, -32768, 32767);
    send_point(FN_START, 0, -32768, 0);
    send_point(FN_END, 0, 32767, 0);
    send_point(FN_START, 0, 32767, -32768);
    send_point(FN_ADD, 1, 1, 1);
    send_point(FN_END, 0, -32768, -32768);
    send_point(FN_START, 0, 0, 0);
    send_point(FN_END, 500, 500, 0);
    send_point(FN_START, 0, 0, 0);
    send_point(FN_END, 0, 0, 0);
    circle_stroke(12, 0);

    write_threshold(16'd0);
    line_stroke(3);
    write_threshold(16'hFFFF);
    line_stroke(3);
    write_threshold(THR_RESET);

    strokes = 0;
    while (sent < 1150) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      if (strokes == 15 || strokes == 55) full_stroke(0);
      else if (strokes == 35) full_stroke(1);
      else begin
        kind = $urandom_range(0, 9);
        if (kind < 4) line_stroke($urandom_range(2, 12));
        else if (kind < 7) circle_stroke($urandom_range(10, 24), $urandom_range(0, 40));
        else if (kind < 9) noise_stroke($urandom_range(2, 14));
        else send_point(func_t'($urandom_range(0, 3)), rnd_coord(), rnd_coord(),
                        rnd_coord());
      end
      strokes++;
      if (strokes % 12 == 0)
        write_threshold($urandom_range(0, 1) ? thr_set[$urandom_range(0, 4)]
                                             : 16'($urandom()));
    end
    s_tvalid = 0;
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (sb.mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #80_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/core/gsc_pkg.sv
rtl/core/gsc_mul.sv
rtl/core/gsc_sqrt.sv
rtl/core/gsc_dp.sv
rtl/core/gsc_ctrl.sv
rtl/core/gesture_swipe_circle_classifier_top.sv
sim/tb_gesture_swipe_circle_classifier_top.sv
